// File: src/assert_macros.svh
// assertion helpers used by the interpolator unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define EWVI_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define EWVI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EWVI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ewvi_pkg.sv
package ewvi_pkg;

    localparam int MAX_VARYINGS   = 16;
    localparam int LERP_FRAC_BITS = 16;

    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int POS_W    = 16;
    localparam int POS_FRAC = 4;
    localparam int PIX_W    = 12;
    localparam int VAL_W    = 32;

    localparam int AMT_W     = LERP_FRAC_BITS + 1;
    localparam int DIV_STEPS = AMT_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);
    localparam int XPROD_W   = PIX_W + 1 + AMT_W + 1;
    localparam int PROD_W    = VAL_W + 1 + AMT_W + 1;

    localparam logic [AMT_W-1:0] AMOUNT_ONE  = {1'b1, {LERP_FRAC_BITS{1'b0}}};
    localparam logic [AMT_W-1:0] AMOUNT_HALF = AMOUNT_ONE >> 1;
    localparam logic [POS_W:0]   POS_HALF    = (POS_W+1)'(1) << (POS_FRAC - 1);

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_SET  = 2'd1,
        KIND_STEP = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        varying_index;
        logic signed [VAL_W-1:0] varying_start;
        logic signed [VAL_W-1:0] varying_end;
        logic [POS_W-1:0]        x_start;
        logic [POS_W-1:0]        y_start;
        logic [POS_W-1:0]        x_end;
        logic [POS_W-1:0]        y_end;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]        pixel_x;
        logic [PIX_W-1:0]        pixel_y;
        logic [IDX_W-1:0]        out_index;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out_item;

    // control that travels along the interpolation pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             zero;
    } t_tag;

endpackage

// File: src/ewvi_if.sv
interface ewvi_in_if import ewvi_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ewvi_out_if import ewvi_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ewvi_cfg_if import ewvi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/edge_walker_varying_interpolator_unit.sv
// Edge walker with varying interpolation.
// i_in carries load, set and step transactions; o_out returns one run of results per
// set or step: pixel x, pixel y and one interpolated varying per result, last flagged.
// A load writes a start/end pair into the varying memory and returns nothing.
// i_cfg writes varying_count; it is always ready and must be written only while idle,
// which the block itself does not enforce. i_in is ready only while no run is in flight.
// A step holds i_in.ready low while it forms x and y, issues one memory read per varying
// (n = max(varying_count, 1) reads, at most 16) and waits for the read, multiply and round
// stages to empty, so the next transaction is taken only after the run has drained.
// A set with a positive dy first runs the bit-serial 1/dy divider. Results follow one
// per cycle while o_out does not stall.
// Each varying goes through the shared 33x18 multiplier once.
// When o_out stalls, the whole read pipeline holds; the last result waits in the
// output register while the next input transaction may already be taken.
// Reset clears the edge state, the amount, the step and varying_count; the
// varying memory is not cleared and must be loaded before it is read.
`include "assert_macros.svh"

module edge_walker_varying_interpolator_unit import ewvi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ewvi_in_if.sink      i_in,
    ewvi_out_if.source   o_out,
    ewvi_cfg_if.sink     i_cfg
);

    t_state             r_state, n_state;
    logic [PIX_W-1:0]   r_sx, n_sx, r_ex, n_ex, r_sy, n_sy, r_ey, n_ey;
    logic [AMT_W-1:0]   r_step, n_step, r_amount, n_amount;
    logic [PIX_W-1:0]   r_dy, n_dy, r_rem, n_rem;
    logic [AMT_W-1:0]   r_num, n_num;
    logic [DIV_CW-1:0]  r_div_cnt, n_div_cnt;
    logic [PIX_W-1:0]   r_px, n_px, r_py, n_py;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_vcount;

    logic [2*VAL_W-1:0] mem [MAX_VARYINGS];
    logic [2*VAL_W-1:0] r_rd;

    t_tag                     r_s1, r_s2, r_s3, issue_tag;
    logic signed [VAL_W-1:0]  r_s2_base, r_s3_base;
    logic signed [VAL_W:0]    r_s2_diff;
    logic signed [PROD_W-1:0] r_s3_prod;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     in_fire, adv, pipe_busy;
    logic [CNT_W-1:0]         cnt_eff;
    logic [PIX_W:0]           set_dy;
    logic [AMT_W:0]           amt_sum;
    logic [PIX_W:0]           trial, trial_sub;
    logic                     trial_ge;
    logic signed [AMT_W:0]    amt_s;
    logic signed [PIX_W:0]    x_delta, y_delta;
    logic signed [XPROD_W-1:0] x_prod, y_prod;
    logic [XPROD_W-1:0]       x_rnd;
    logic signed [VAL_W:0]    v_diff;
    logic signed [PROD_W-1:0] v_prod;
    logic [PROD_W-1:0]        v_rnd;
    logic [VAL_W-1:0]         v_value;

    function automatic logic [PIX_W-1:0] round_pix(input logic [POS_W-1:0] pos);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + POS_HALF;
        return sum[POS_W] ? {PIX_W{1'b1}} : sum[POS_W-1:POS_FRAC];
    endfunction

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign adv         = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign pipe_busy   = r_s1.valid || r_s2.valid || r_s3.valid;

    assign cnt_eff = (int'(r_vcount) > MAX_VARYINGS) ? CNT_W'(MAX_VARYINGS) : r_vcount;

    assign set_dy  = {1'b0, i_in.data.y_end[POS_W-1:POS_FRAC]}
                   - {1'b0, i_in.data.y_start[POS_W-1:POS_FRAC]};
    assign amt_sum = {1'b0, r_amount} + {1'b0, r_step};

    // one restoring division step per cycle
    assign trial     = {r_rem, r_num[AMT_W-1]};
    assign trial_ge  = trial >= {1'b0, r_dy};
    assign trial_sub = trial - {1'b0, r_dy};

    assign amt_s   = $signed({1'b0, r_amount});
    assign x_delta = $signed({1'b0, r_ex}) - $signed({1'b0, r_sx});
    assign y_delta = $signed({1'b0, r_ey}) - $signed({1'b0, r_sy});
    assign x_prod  = x_delta * amt_s;
    assign y_prod  = y_delta * amt_s;
    assign x_rnd   = x_prod + XPROD_W'(AMOUNT_HALF);

    assign v_diff  = {r_rd[2*VAL_W-1], r_rd[2*VAL_W-1:VAL_W]}
                   - {r_rd[VAL_W-1], r_rd[VAL_W-1:0]};
    assign v_prod  = r_s2_diff * amt_s;
    assign v_rnd   = r_s3_prod + PROD_W'(AMOUNT_HALF);
    assign v_value = r_s3_base + v_rnd[LERP_FRAC_BITS +: VAL_W];

    always_comb begin
        n_state   = r_state;
        n_sx      = r_sx;
        n_ex      = r_ex;
        n_sy      = r_sy;
        n_ey      = r_ey;
        n_step    = r_step;
        n_amount  = r_amount;
        n_dy      = r_dy;
        n_rem     = r_rem;
        n_num     = r_num;
        n_div_cnt = r_div_cnt;
        n_px      = r_px;
        n_py      = r_py;
        n_k       = r_k;
        issue_tag = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.data.kind)
                        KIND_SET: begin
                            n_sx      = round_pix(i_in.data.x_start);
                            n_ex      = round_pix(i_in.data.x_end);
                            n_sy      = i_in.data.y_start[POS_W-1:POS_FRAC];
                            n_ey      = i_in.data.y_end[POS_W-1:POS_FRAC];
                            n_amount  = '0;
                            n_step    = '0;
                            n_rem     = '0;
                            n_div_cnt = '0;
                            n_dy      = set_dy[PIX_W-1:0];
                            n_num     = AMOUNT_ONE + AMT_W'(set_dy[PIX_W-1:1]);
                            if (set_dy == '0) begin
                                n_step  = AMOUNT_ONE;
                                n_state = ST_PREP;
                            end else if (set_dy[PIX_W]) begin
                                // upward edge keeps the amount at zero
                                n_state = ST_PREP;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        KIND_STEP: begin
                            n_amount = (amt_sum > {1'b0, AMOUNT_ONE}) ? AMOUNT_ONE
                                                                      : amt_sum[AMT_W-1:0];
                            n_state  = ST_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                n_rem     = trial_ge ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
                n_num     = r_num << 1;
                n_step    = {r_step[AMT_W-2:0], trial_ge};
                n_div_cnt = r_div_cnt + DIV_CW'(1);
                if (r_div_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_px    = r_sx + x_rnd[LERP_FRAC_BITS +: PIX_W];
                n_py    = r_sy + y_prod[LERP_FRAC_BITS +: PIX_W];
                n_k     = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (adv) begin
                    issue_tag.valid = 1'b1;
                    issue_tag.idx   = r_k;
                    issue_tag.zero  = (cnt_eff == '0);
                    issue_tag.last  = issue_tag.zero
                                   || ((CNT_W'(r_k) + CNT_W'(1)) == cnt_eff);
                    if (issue_tag.last) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sx        <= '0;
            r_ex        <= '0;
            r_sy        <= '0;
            r_ey        <= '0;
            r_step      <= '0;
            r_amount    <= '0;
            r_div_cnt   <= '0;
            r_vcount    <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sx      <= n_sx;
            r_ex      <= n_ex;
            r_sy      <= n_sy;
            r_ey      <= n_ey;
            r_step    <= n_step;
            r_amount  <= n_amount;
            r_div_cnt <= n_div_cnt;
            if (i_cfg.valid) begin
                r_vcount <= i_cfg.data;
            end
            if (adv) begin
                r_s1        <= issue_tag;
                r_s2        <= r_s1;
                r_s3        <= r_s2;
                r_out_valid <= r_s3.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dy  <= n_dy;
        r_rem <= n_rem;
        r_num <= n_num;
        r_px  <= n_px;
        r_py  <= n_py;
        r_k   <= n_k;
        if (adv) begin
            r_s2_base         <= r_rd[VAL_W-1:0];
            r_s2_diff         <= v_diff;
            r_s3_base         <= r_s2_base;
            r_s3_prod         <= v_prod;
            r_out.pixel_x     <= r_px;
            r_out.pixel_y     <= r_py;
            r_out.out_index   <= r_s3.idx;
            r_out.out_value   <= r_s3.zero ? '0 : v_value;
            r_out.last        <= r_s3.last;
        end
    end

    // varying memory: start in the low half, end in the high half
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.data.kind == KIND_LOAD)) begin
            mem[i_in.data.varying_index] <= {i_in.data.varying_end, i_in.data.varying_start};
        end
        if (adv) begin
            r_rd <= mem[r_k];
        end
    end

    `EWVI_ASSERT_NOW(a_amount_cap, i_clk, i_rst_n, r_amount <= AMOUNT_ONE, "amount above one")
    `EWVI_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, i_in.ready, !pipe_busy, "ready while busy")
    `EWVI_ASSERT_NXT(a_last_drain, i_clk, i_rst_n, issue_tag.last, r_state == ST_DRAIN, "no drain")

endmodule
